// ===== hdl/tcc_pkg.sv =====
// ---------------------------------------------------------------------------
// tcc_pkg
// Types, codes and helper functions shared by the TCP connection controller.
// ---------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

	localparam int unsigned RX_CAPACITY = 4096;
	localparam int unsigned MAX_SEGMENT = 1460;

	localparam logic [15:0] RETRANSMIT_RESET = 16'd1000;
	localparam logic [15:0] TIME_WAIT_RESET  = 16'd1000;
	localparam logic [3:0]  MAX_RETRY_RESET  = 4'd3;

	// Bit positions in the TCP flag byte.
	localparam int unsigned FL_FIN_BIT = 0;
	localparam int unsigned FL_SYN_BIT = 1;
	localparam int unsigned FL_RST_BIT = 2;
	localparam int unsigned FL_ACK_BIT = 4;
	localparam logic [7:0] FL_SYN    = 8'h02;
	localparam logic [7:0] FL_ACK    = 8'h10;
	localparam logic [7:0] FL_FINACK = 8'h11;

	typedef enum logic [2:0] {
		ACT_SEGMENT = 3'd0,
		ACT_TICK    = 3'd1,
		ACT_CONNECT = 3'd2,
		ACT_SEND    = 3'd3,
		ACT_CLOSE   = 3'd4,
		ACT_READ    = 3'd5,
		ACT_ABORT   = 3'd6,
		ACT_UNKNOWN = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_CLOSED      = 3'd0,
		ST_SYN_SENT    = 3'd1,
		ST_ESTABLISHED = 3'd2,
		ST_FIN_WAIT1   = 3'd3,
		ST_FIN_WAIT2   = 3'd4,
		ST_CLOSE_WAIT  = 3'd5,
		ST_LAST_ACK    = 3'd6,
		ST_TIME_WAIT   = 3'd7
	} conn_state_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_RESET   = 3'd1,
		STS_TIMEOUT = 3'd2,
		STS_FULL    = 3'd3,
		STS_BUSY    = 3'd4,
		STS_INVALID = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KIND_STATUS   = 2'd0,
		KIND_TRANSMIT = 2'd1,
		KIND_STORE    = 2'd2
	} kind_t;

	localparam logic [1:0] CFG_RETRANSMIT = 2'd0;
	localparam logic [1:0] CFG_TIME_WAIT  = 2'd1;
	localparam logic [1:0] CFG_MAX_RETRY  = 2'd2;

	typedef enum logic [2:0] {
		C_IDLE,
		C_ACK,
		C_MAIN,
		C_OUT0,
		C_OUT1
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  seg_flags;
		logic [31:0] seg_sequence;
		logic [31:0] seg_ack;
		logic [15:0] seg_window;
		logic [10:0] seg_length;
		logic [31:0] initial_sequence;
		logic [12:0] read_capacity;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] out_sequence;
		logic [31:0] tx_ack;
		logic [7:0]  out_flags;
		logic [10:0] out_length;
		logic [11:0] rx_write_offset;
		logic [12:0] rx_available;
		logic [12:0] read_taken;
		logic [10:0] tx_trim;
		logic [2:0]  conn_state;
		logic [2:0]  status;
		logic        last;
	} result_t;

	// One transmit order held for output.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [7:0]  flags;
		logic [10:0] len;
	} order_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic ack_en;
		logic main_en;
		logic sel;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic two;
	} dp_stat_t;

	// True when sequence number a lies before b in modular order.
	function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	// Sequence space taken by a segment.
	function automatic logic [11:0] seq_space(input logic [7:0] flags,
			input logic [10:0] len);
		return {1'b0, len} + {11'd0, flags[FL_SYN_BIT]} + {11'd0, flags[FL_FIN_BIT]};
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tcc_if.sv =====
// ---------------------------------------------------------------------------
// tcc_if
// Channel interfaces of the TCP connection controller: items in, results
// out and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface tcc_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [7:0]  seg_flags;
	logic [31:0] seg_sequence;
	logic [31:0] seg_ack;
	logic [15:0] seg_window;
	logic [10:0] seg_length;
	logic [31:0] initial_sequence;
	logic [12:0] read_capacity;

	modport source (output valid, action, seg_flags, seg_sequence, seg_ack, seg_window,
		seg_length, initial_sequence, read_capacity, input ready);
	modport sink (input valid, action, seg_flags, seg_sequence, seg_ack, seg_window,
		seg_length, initial_sequence, read_capacity, output ready);
endinterface

interface tcc_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] out_sequence;
	logic [31:0] tx_ack;
	logic [7:0]  out_flags;
	logic [10:0] out_length;
	logic [11:0] rx_write_offset;
	logic [12:0] rx_available;
	logic [12:0] read_taken;
	logic [10:0] tx_trim;
	logic [2:0]  conn_state;
	logic [2:0]  status;
	logic        last;

	modport source (output valid, kind, out_sequence, tx_ack, out_flags, out_length,
		rx_write_offset, rx_available, read_taken, tx_trim, conn_state, status, last,
		input ready);
	modport sink (input valid, kind, out_sequence, tx_ack, out_flags, out_length,
		rx_write_offset, rx_available, read_taken, tx_trim, conn_state, status, last,
		output ready);
endinterface

interface tcc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tcc_datapath.sv =====
// ---------------------------------------------------------------------------
// tcc_datapath
// Connection state, sequence arithmetic, timers and the result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tcc_pkg::dp_cmd_t cmd,
	output tcc_pkg::dp_stat_t    stat,
	input  wire tcc_pkg::item_t  item,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [15:0]     cfg_data,
	output tcc_pkg::result_t     result
);

	// Registers and connection state.
	logic [15:0] rtx_ticks_q, tw_ticks_q, rto_q, twc_q, pwin_q;
	logic [3:0]  max_retry_q, retry_q;
	logic [2:0]  st_q, sts_q, code_q;
	logic        active_q, outst_q, pfin_q, ackp_q, answer_q, two_q;
	logic [31:0] una_q, nxt_q, rcv_q, pseq_q;
	logic [7:0]  pflg_q;
	logic [10:0] plen_q, trim_q;
	logic [12:0] rxc_q, taken_q;
	logic [11:0] offset_q;
	tcc_pkg::item_t  it_q;
	tcc_pkg::order_t r0_q, r1_q;

	// Acknowledge processing terms.
	logic        a_rst, a_synack, a_go, pa_bad, pa_full, pa_part, pa_outst;
	logic [31:0] pa_end, pa_done;
	// Main phase terms.
	logic [12:0] rx_free, rd_take;
	logic        b_fit, tw_exp, rto_exp, rt_fail;
	logic [10:0] ch1, ch2;

	assign a_rst    = it_q.seg_flags[tcc_pkg::FL_RST_BIT];
	assign a_synack = it_q.seg_flags[tcc_pkg::FL_SYN_BIT] &&
		it_q.seg_flags[tcc_pkg::FL_ACK_BIT] && (it_q.seg_ack == nxt_q);
	assign a_go = (st_q == tcc_pkg::ST_SYN_SENT) ? a_synack :
		it_q.seg_flags[tcc_pkg::FL_ACK_BIT];
	assign pa_bad = tcc_pkg::seq_before(it_q.seg_ack, una_q) ||
		tcc_pkg::seq_before(nxt_q, it_q.seg_ack) || (it_q.seg_ack == una_q);
	assign pa_end  = pseq_q + {20'd0, tcc_pkg::seq_space(pflg_q, plen_q)};
	assign pa_full = !tcc_pkg::seq_before(it_q.seg_ack, pa_end);
	assign pa_done = it_q.seg_ack - pseq_q;
	assign pa_part = !pflg_q[tcc_pkg::FL_SYN_BIT] && !pflg_q[tcc_pkg::FL_FIN_BIT] &&
		!tcc_pkg::seq_before(it_q.seg_ack, pseq_q) && (pa_done <= {21'd0, plen_q});
	assign pa_outst = outst_q && !pa_full;

	assign rx_free = 13'(tcc_pkg::RX_CAPACITY) - rxc_q;
	assign b_fit   = {2'd0, it_q.seg_length} <= rx_free;
	assign rd_take = (rxc_q < it_q.read_capacity) ? rxc_q : it_q.read_capacity;
	assign tw_exp  = (st_q == tcc_pkg::ST_TIME_WAIT) && (twc_q <= 16'd1);
	assign rto_exp = rto_q <= 16'd1;
	assign rt_fail = retry_q >= max_retry_q;
	assign ch1 = (it_q.seg_length > 11'(tcc_pkg::MAX_SEGMENT)) ?
		11'(tcc_pkg::MAX_SEGMENT) : it_q.seg_length;
	assign ch2 = ({5'd0, ch1} > pwin_q) ? pwin_q[10:0] : ch1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtx_ticks_q <= tcc_pkg::RETRANSMIT_RESET;
			tw_ticks_q  <= tcc_pkg::TIME_WAIT_RESET;
			max_retry_q <= tcc_pkg::MAX_RETRY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tcc_pkg::CFG_RETRANSMIT: rtx_ticks_q <= cfg_data;
				tcc_pkg::CFG_TIME_WAIT:  tw_ticks_q  <= cfg_data;
				tcc_pkg::CFG_MAX_RETRY:  max_retry_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Item capture, acknowledge phase and main phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tcc_pkg::ST_CLOSED; sts_q <= tcc_pkg::STS_OK; active_q <= 1'b0;
			una_q <= '0; nxt_q <= '0; rcv_q <= '0; pwin_q <= '0; rxc_q <= '0;
			pseq_q <= '0; pflg_q <= '0; plen_q <= '0; outst_q <= 1'b0;
			retry_q <= '0; rto_q <= '0; twc_q <= '0; pfin_q <= 1'b0; ackp_q <= 1'b0;
			trim_q <= '0; taken_q <= '0; offset_q <= '0; answer_q <= 1'b0;
			code_q <= tcc_pkg::STS_OK; two_q <= 1'b0; r0_q <= '0; r1_q <= '0;
			it_q <= '0;
		end else if (cmd.load) begin
			it_q   <= item;
			trim_q <= '0;
		end else if (cmd.ack_en) begin
			if (it_q.action == tcc_pkg::ACT_SEGMENT && active_q) begin
				pwin_q <= it_q.seg_window;
				if (a_rst) begin
					sts_q <= tcc_pkg::STS_RESET; st_q <= tcc_pkg::ST_CLOSED;
					outst_q <= 1'b0; active_q <= 1'b0;
				end else if (a_go && !pa_bad) begin
					una_q <= it_q.seg_ack;
					if (outst_q) begin
						if (pa_full) begin
							trim_q <= plen_q; outst_q <= 1'b0; retry_q <= '0;
						end else if (pa_part) begin
							trim_q <= pa_done[10:0];
							plen_q <= plen_q - pa_done[10:0];
							pseq_q <= it_q.seg_ack;
							rto_q  <= rtx_ticks_q;
						end
					end
					if (st_q == tcc_pkg::ST_FIN_WAIT1 && !pa_outst) begin
						if (pfin_q) begin
							st_q <= tcc_pkg::ST_TIME_WAIT; twc_q <= tw_ticks_q;
						end else begin
							st_q <= tcc_pkg::ST_FIN_WAIT2;
						end
					end else if (st_q == tcc_pkg::ST_LAST_ACK && !pa_outst) begin
						st_q <= tcc_pkg::ST_CLOSED; active_q <= 1'b0;
					end
				end
			end
		end else if (cmd.main_en) begin
			answer_q <= 1'b0; code_q <= tcc_pkg::STS_OK; two_q <= 1'b0;
			offset_q <= '0; taken_q <= '0; r0_q <= '0;
			case (it_q.action)
				tcc_pkg::ACT_SEGMENT: begin
					if (active_q && !a_rst) begin
						if (st_q == tcc_pkg::ST_SYN_SENT) begin
							if (a_synack) begin
								rcv_q <= it_q.seg_sequence + 32'd1;
								st_q <= tcc_pkg::ST_ESTABLISHED;
								ackp_q <= 1'b1;
							end
						end else if (st_q != tcc_pkg::ST_CLOSED &&
								(it_q.seg_length != '0 ||
								it_q.seg_flags[tcc_pkg::FL_FIN_BIT])) begin
							if (it_q.seg_sequence != rcv_q) begin
								ackp_q <= 1'b1;
							end else if (!b_fit) begin
								sts_q <= tcc_pkg::STS_FULL; ackp_q <= 1'b1;
							end else begin
								if (it_q.seg_length != '0) begin
									offset_q <= rxc_q[11:0];
									r0_q.kind <= tcc_pkg::KIND_STORE;
									ackp_q <= 1'b1;
								end
								rxc_q <= rxc_q + {2'd0, it_q.seg_length};
								rcv_q <= rcv_q + {21'd0, it_q.seg_length} +
									{31'd0, it_q.seg_flags[tcc_pkg::FL_FIN_BIT]};
								if (it_q.seg_flags[tcc_pkg::FL_FIN_BIT]) begin
									pfin_q <= 1'b1; ackp_q <= 1'b1;
									if (st_q == tcc_pkg::ST_ESTABLISHED) begin
										st_q <= tcc_pkg::ST_CLOSE_WAIT;
									end else if (st_q == tcc_pkg::ST_FIN_WAIT2) begin
										st_q <= tcc_pkg::ST_TIME_WAIT;
										twc_q <= tw_ticks_q;
									end
								end
							end
						end
					end
				end
				tcc_pkg::ACT_TICK: begin
					if (ackp_q) begin
						r0_q <= '{tcc_pkg::KIND_TRANSMIT, nxt_q, rcv_q, tcc_pkg::FL_ACK,
							11'd0};
						ackp_q <= 1'b0;
					end
					if (tw_exp) begin
						twc_q <= '0; st_q <= tcc_pkg::ST_CLOSED; active_q <= 1'b0;
					end else begin
						if (st_q == tcc_pkg::ST_TIME_WAIT) begin
							twc_q <= twc_q - 16'd1;
						end
						if (outst_q) begin
							if (rto_exp) begin
								if (rt_fail) begin
									sts_q <= tcc_pkg::STS_TIMEOUT;
									st_q <= tcc_pkg::ST_CLOSED;
									outst_q <= 1'b0; active_q <= 1'b0;
								end else begin
									if (ackp_q) begin
										r1_q <= '{tcc_pkg::KIND_TRANSMIT, pseq_q, rcv_q,
											pflg_q, plen_q};
										two_q <= 1'b1;
									end else begin
										r0_q <= '{tcc_pkg::KIND_TRANSMIT, pseq_q, rcv_q,
											pflg_q, plen_q};
									end
									retry_q <= retry_q + 4'd1;
									rto_q <= rtx_ticks_q;
								end
							end else begin
								rto_q <= rto_q - 16'd1;
							end
						end
					end
				end
				tcc_pkg::ACT_CONNECT: begin
					answer_q <= 1'b1;
					if (active_q) begin
						code_q <= tcc_pkg::STS_BUSY;
					end else begin
						sts_q <= tcc_pkg::STS_OK; active_q <= 1'b1;
						una_q <= it_q.initial_sequence;
						nxt_q <= it_q.initial_sequence + 32'd1;
						rcv_q <= '0; pwin_q <= '0; rxc_q <= '0;
						pseq_q <= it_q.initial_sequence; pflg_q <= tcc_pkg::FL_SYN;
						plen_q <= '0; outst_q <= 1'b1; retry_q <= '0;
						rto_q <= rtx_ticks_q; twc_q <= '0; pfin_q <= 1'b0;
						ackp_q <= 1'b0; st_q <= tcc_pkg::ST_SYN_SENT;
						r0_q <= '{tcc_pkg::KIND_TRANSMIT, it_q.initial_sequence, 32'd0,
							tcc_pkg::FL_SYN, 11'd0};
					end
				end
				tcc_pkg::ACT_SEND: begin
					answer_q <= 1'b1;
					if (st_q != tcc_pkg::ST_ESTABLISHED) begin
						code_q <= tcc_pkg::STS_INVALID;
					end else if (it_q.seg_length == '0) begin
						code_q <= tcc_pkg::STS_OK;
					end else if (pwin_q == '0) begin
						code_q <= tcc_pkg::STS_TIMEOUT;
					end else if (outst_q) begin
						code_q <= tcc_pkg::STS_INVALID;
					end else begin
						pseq_q <= nxt_q; pflg_q <= it_q.seg_flags; plen_q <= ch2;
						outst_q <= 1'b1; retry_q <= '0; rto_q <= rtx_ticks_q;
						nxt_q <= nxt_q + {20'd0, tcc_pkg::seq_space(it_q.seg_flags, ch2)};
						r0_q <= '{tcc_pkg::KIND_TRANSMIT, nxt_q, rcv_q, it_q.seg_flags,
							ch2};
					end
				end
				tcc_pkg::ACT_CLOSE: begin
					answer_q <= 1'b1;
					if (st_q == tcc_pkg::ST_ESTABLISHED || st_q == tcc_pkg::ST_CLOSE_WAIT) begin
						if (outst_q) begin
							code_q <= tcc_pkg::STS_BUSY;
						end else begin
							st_q <= (st_q == tcc_pkg::ST_ESTABLISHED) ?
								tcc_pkg::ST_FIN_WAIT1 : tcc_pkg::ST_LAST_ACK;
							pseq_q <= nxt_q; pflg_q <= tcc_pkg::FL_FINACK; plen_q <= '0;
							outst_q <= 1'b1; retry_q <= '0; rto_q <= rtx_ticks_q;
							nxt_q <= nxt_q + 32'd1;
							r0_q <= '{tcc_pkg::KIND_TRANSMIT, nxt_q, rcv_q,
								tcc_pkg::FL_FINACK, 11'd0};
						end
					end else if (st_q == tcc_pkg::ST_CLOSED) begin
						active_q <= 1'b0; code_q <= sts_q;
					end else if (st_q == tcc_pkg::ST_SYN_SENT) begin
						code_q <= tcc_pkg::STS_INVALID;
					end
				end
				tcc_pkg::ACT_READ: begin
					taken_q <= rd_take;
					rxc_q <= rxc_q - rd_take;
				end
				tcc_pkg::ACT_ABORT: begin
					st_q <= tcc_pkg::ST_CLOSED; sts_q <= tcc_pkg::STS_OK; active_q <= 1'b0;
					una_q <= '0; nxt_q <= '0; rcv_q <= '0; pwin_q <= '0; rxc_q <= '0;
					pseq_q <= '0; pflg_q <= '0; plen_q <= '0; outst_q <= 1'b0;
					retry_q <= '0; rto_q <= '0; twc_q <= '0; pfin_q <= 1'b0;
					ackp_q <= 1'b0;
				end
				default: begin
					answer_q <= 1'b1; code_q <= tcc_pkg::STS_INVALID;
				end
			endcase
		end
	end

	// Result assembly from the held orders and the state after the step.
	tcc_pkg::order_t ord;
	assign ord = cmd.sel ? r1_q : r0_q;
	assign stat.two = two_q;

	always_comb begin
		result.kind            = ord.kind;
		result.out_sequence    = ord.seq;
		result.tx_ack          = ord.ack;
		result.out_flags       = ord.flags;
		result.out_length      = ord.len;
		result.rx_write_offset = offset_q;
		result.rx_available    = rxc_q;
		result.read_taken      = taken_q;
		result.tx_trim         = trim_q;
		result.conn_state      = st_q;
		result.status          = answer_q ? code_q : sts_q;
		result.last            = cmd.sel || !two_q;
	end

endmodule

`default_nettype wire

// ===== hdl/tcc_ctrl.sv =====
// ---------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: takes one item, steps the datapath through its two phases and
// hands out one or two results.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tcc_pkg::dp_cmd_t       cmd,
	input  wire tcc_pkg::dp_stat_t stat
);

	tcc_pkg::ctrl_state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcc_pkg::C_IDLE: if (in_valid) state_d = tcc_pkg::C_ACK;
			tcc_pkg::C_ACK:  state_d = tcc_pkg::C_MAIN;
			tcc_pkg::C_MAIN: state_d = tcc_pkg::C_OUT0;
			tcc_pkg::C_OUT0: begin
				if (out_ready) state_d = stat.two ? tcc_pkg::C_OUT1 : tcc_pkg::C_IDLE;
			end
			tcc_pkg::C_OUT1: if (out_ready) state_d = tcc_pkg::C_IDLE;
			default: state_d = tcc_pkg::C_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd         = '0;
		case (state_q)
			tcc_pkg::C_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			tcc_pkg::C_ACK:  cmd.ack_en = 1'b1;
			tcc_pkg::C_MAIN: cmd.main_en = 1'b1;
			tcc_pkg::C_OUT0: out_valid = 1'b1;
			tcc_pkg::C_OUT1: begin
				out_valid = 1'b1;
				cmd.sel   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcc_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// An item is never taken while a result is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while result pending");

	// An accepted item starts the acknowledge phase next cycle.
	a_accept_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == tcc_pkg::C_ACK)
		else $error("accepted item did not start processing");

	// The second result only follows the first.
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == tcc_pkg::C_OUT1) |-> ($past(state_q) == tcc_pkg::C_OUT0 &&
		$past(stat.two))) else $error("second result without a first");

endmodule

`default_nettype wire

// ===== hdl/tcp_connection_controller.sv =====
// ---------------------------------------------------------------------------
// tcp_connection_controller
// Control engine for one TCP connection with a single outstanding segment.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake      Payload
//  item_in   in         valid/ready    action, segment fields, commands
//  result_o  out        valid/ready    transmit order, offsets, state, status
//  cfg       in         valid/ready    register index, 16-bit data
//
//  An item is processed in capture, acknowledge phase and main phase, and
//  then gives one result per cycle while the sink is ready; only a tick
//  can give two results.
//  The sequencer holds one item at a time; input ready is low from capture
//  until the last result is taken. A stalled result holds.
//  Reset restores the register defaults and a closed connection.
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_connection_controller (
	input wire logic   clk,
	input wire logic   arst_n,
	tcc_item_if.sink   item_in,
	tcc_result_if.source result_o,
	tcc_cfg_if.sink    cfg
);

	tcc_pkg::dp_cmd_t  cmd;
	tcc_pkg::dp_stat_t stat;
	tcc_pkg::item_t    item;
	tcc_pkg::result_t  res;

	assign item.action           = item_in.action;
	assign item.seg_flags        = item_in.seg_flags;
	assign item.seg_sequence     = item_in.seg_sequence;
	assign item.seg_ack          = item_in.seg_ack;
	assign item.seg_window       = item_in.seg_window;
	assign item.seg_length       = item_in.seg_length;
	assign item.initial_sequence = item_in.initial_sequence;
	assign item.read_capacity    = item_in.read_capacity;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	tcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_ready  (item_in.ready),
		.out_valid (result_o.valid),
		.out_ready (result_o.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tcc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.result    (res)
	);

	assign result_o.kind            = res.kind;
	assign result_o.out_sequence    = res.out_sequence;
	assign result_o.tx_ack          = res.tx_ack;
	assign result_o.out_flags       = res.out_flags;
	assign result_o.out_length      = res.out_length;
	assign result_o.rx_write_offset = res.rx_write_offset;
	assign result_o.rx_available    = res.rx_available;
	assign result_o.read_taken      = res.read_taken;
	assign result_o.tx_trim         = res.tx_trim;
	assign result_o.conn_state      = res.conn_state;
	assign result_o.status          = res.status;
	assign result_o.last            = res.last;

endmodule

`default_nettype wire

// ===== bench/tb_scoreboard.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_scoreboard
// Expected-result queue for the TCP connection controller bench. The bench
// works out the results of each accepted item and notes them here; every
// result taken from the block is checked against the oldest one.
// ---------------------------------------------------------------------------

class tcc_scoreboard;
	tcc_pkg::result_t pending_results[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// Note one result that an accepted item causes.
	function void note_item(tcc_pkg::result_t r);
		pending_results.push_back(r);
	endfunction

	// Compare one result from the block with the oldest expectation.
	function void check_result(tcc_pkg::result_t got);
		tcc_pkg::result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result %h", $realtime, got);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (want.kind != got.kind) begin
			$display("%0t: kind exp %0d act %0d", $realtime, want.kind, got.kind);
			errors++;
		end
		if (want.out_sequence != got.out_sequence) begin
			$display("%0t: out_sequence exp %h act %h", $realtime, want.out_sequence,
				got.out_sequence);
			errors++;
		end
		if (want.tx_ack != got.tx_ack) begin
			$display("%0t: tx_ack exp %h act %h", $realtime, want.tx_ack, got.tx_ack);
			errors++;
		end
		if (want.out_flags != got.out_flags) begin
			$display("%0t: out_flags exp %h act %h", $realtime, want.out_flags,
				got.out_flags);
			errors++;
		end
		if (want.out_length != got.out_length) begin
			$display("%0t: out_length exp %0d act %0d", $realtime, want.out_length,
				got.out_length);
			errors++;
		end
		if (want.rx_write_offset != got.rx_write_offset) begin
			$display("%0t: rx_write_offset exp %0d act %0d", $realtime,
				want.rx_write_offset, got.rx_write_offset);
			errors++;
		end
		if (want.rx_available != got.rx_available) begin
			$display("%0t: rx_available exp %0d act %0d", $realtime, want.rx_available,
				got.rx_available);
			errors++;
		end
		if (want.read_taken != got.read_taken) begin
			$display("%0t: read_taken exp %0d act %0d", $realtime, want.read_taken,
				got.read_taken);
			errors++;
		end
		if (want.tx_trim != got.tx_trim) begin
			$display("%0t: tx_trim exp %0d act %0d", $realtime, want.tx_trim, got.tx_trim);
			errors++;
		end
		if (want.conn_state != got.conn_state) begin
			$display("%0t: conn_state exp %0d act %0d", $realtime, want.conn_state,
				got.conn_state);
			errors++;
		end
		if (want.status != got.status) begin
			$display("%0t: status exp %0d act %0d", $realtime, want.status, got.status);
			errors++;
		end
		if (want.last != got.last) begin
			$display("%0t: last exp %0d act %0d", $realtime, want.last, got.last);
			errors++;
		end
	endfunction
endclass

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Bench for the TCP connection controller. Directed items walk the
// handshake, data transfer, both close paths, timers and error answers;
// then random traffic mostly drives well-formed connections with random
// content. A connection model in the bench predicts every result, and
// both channels idle at random, with one long output stall.
// ---------------------------------------------------------------------------

module tb;
	import tcc_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam logic [7:0] F_FIN = 8'h01;
	localparam logic [7:0] F_RST = 8'h04;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tcc_item_if   item_ch ();
	tcc_result_if res_ch ();
	tcc_cfg_if    cfg_ch ();

	tcp_connection_controller uut (
		.clk(clk), .arst_n(arst_n), .item_in(item_ch.sink),
		.result_o(res_ch.source), .cfg(cfg_ch.sink)
	);

	always #6 clk = ~clk;

	tcc_scoreboard board = new();
	int cycle_count = 0;
	bit quiet_phase = 1'b0;
	bit long_stall = 1'b0;

	// Connection model state and registers.
	logic [15:0] m_rto, m_twt;
	logic [3:0]  m_retries;
	conn_state_t m_state;
	logic [2:0]  m_status;
	logic        m_active, m_outst, m_peer_fin, m_ackp;
	logic [31:0] m_una, m_nxt, m_rnxt, m_pseq;
	logic [15:0] m_pwin, m_rto_cnt, m_tw_cnt;
	logic [12:0] m_rxc;
	logic [7:0]  m_pflags;
	logic [10:0] m_plen;
	logic [3:0]  m_retry;
	order_t      tx_orders[$];

	initial begin
		item_ch.valid = 1'b0;
		item_ch.action = '0;
		item_ch.seg_flags = '0;
		item_ch.seg_sequence = '0;
		item_ch.seg_ack = '0;
		item_ch.seg_window = '0;
		item_ch.seg_length = '0;
		item_ch.initial_sequence = '0;
		item_ch.read_capacity = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
	end

	// Cycle counter with the run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result sink: random idling bursts and one long stall.
	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (long_stall) begin
				res_ch.ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 4);
				res_ch.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Checks every accepted result.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			board.check_result({res_ch.kind, res_ch.out_sequence, res_ch.tx_ack,
				res_ch.out_flags, res_ch.out_length, res_ch.rx_write_offset,
				res_ch.rx_available, res_ch.read_taken, res_ch.tx_trim,
				res_ch.conn_state, res_ch.status, res_ch.last});
		end
	end

	function automatic bit seq_lt(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic logic [31:0] space_of(logic [7:0] f, logic [10:0] len);
		return 32'(len) + 32'(f[1]) + 32'(f[0]);
	endfunction

	task automatic clear_conn();
		m_state = ST_CLOSED; m_status = STS_OK; m_active = 0;
		m_una = 0; m_nxt = 0; m_rnxt = 0; m_pwin = 0; m_rxc = 0;
		m_pseq = 0; m_pflags = 0; m_plen = 0; m_outst = 0; m_retry = 0;
		m_rto_cnt = 0; m_tw_cnt = 0; m_peer_fin = 0; m_ackp = 0;
	endtask

	task automatic queue_tx(logic [31:0] s, logic [31:0] a, logic [7:0] f, logic [10:0] l);
		order_t o;
		if (tx_orders.size() >= 2) return;
		o.kind = KIND_TRANSMIT; o.seq = s; o.ack = a; o.flags = f; o.len = l;
		tx_orders.push_back(o);
	endtask

	task automatic drop_conn(logic [2:0] code);
		m_status = code; m_state = ST_CLOSED; m_outst = 0; m_active = 0;
	endtask

	task automatic send_segment(logic [7:0] f, logic [10:0] l);
		m_pseq = m_nxt; m_pflags = f; m_plen = l;
		m_outst = 1; m_retry = 0; m_rto_cnt = m_rto;
		m_nxt = m_nxt + space_of(f, l);
		queue_tx(m_pseq, m_rnxt, m_pflags, m_plen);
	endtask

	function automatic logic [10:0] apply_ack(logic [31:0] a);
		logic [10:0] trim;
		logic [31:0] seg_end, done;
		trim = 0;
		if (seq_lt(a, m_una) || seq_lt(m_nxt, a)) return 0;
		if (a == m_una) return 0;
		m_una = a;
		if (m_outst) begin
			seg_end = m_pseq + space_of(m_pflags, m_plen);
			if (!seq_lt(a, seg_end)) begin
				trim = m_plen; m_outst = 0; m_retry = 0;
			end else if ((m_pflags & 8'h03) == 0 && !seq_lt(a, m_pseq)) begin
				done = a - m_pseq;
				if (done <= 32'(m_plen)) begin
					trim = done[10:0];
					m_plen = m_plen - done[10:0];
					m_pseq = a;
					m_rto_cnt = m_rto;
				end
			end
		end
		if (m_state == ST_FIN_WAIT1 && !m_outst) begin
			if (m_peer_fin) begin
				m_state = ST_TIME_WAIT; m_tw_cnt = m_twt;
			end else begin
				m_state = ST_FIN_WAIT2;
			end
		end else if (m_state == ST_LAST_ACK && !m_outst) begin
			m_state = ST_CLOSED; m_active = 0;
		end
		return trim;
	endfunction

	function automatic bit take_payload(logic [7:0] f, logic [31:0] s, logic [10:0] l,
			ref logic [11:0] off);
		bit stored;
		stored = 0;
		if (s != m_rnxt) begin
			m_ackp = 1;
			return 0;
		end
		if (32'(l) > 32'(RX_CAPACITY) - 32'(m_rxc)) begin
			m_status = STS_FULL; m_ackp = 1;
			return 0;
		end
		if (l != 0) begin
			off = m_rxc[11:0]; stored = 1; m_ackp = 1;
		end
		m_rxc = m_rxc + 13'(l);
		m_rnxt = m_rnxt + 32'(l);
		if (f[0]) begin
			m_rnxt = m_rnxt + 1; m_peer_fin = 1;
			if (m_state == ST_ESTABLISHED) begin
				m_state = ST_CLOSE_WAIT;
			end else if (m_state == ST_FIN_WAIT2) begin
				m_state = ST_TIME_WAIT; m_tw_cnt = m_twt;
			end
			m_ackp = 1;
		end
		return stored;
	endfunction

	task automatic run_tick();
		if (m_ackp) begin
			queue_tx(m_nxt, m_rnxt, FL_ACK, 0);
			m_ackp = 0;
		end
		if (m_state == ST_TIME_WAIT) begin
			if (m_tw_cnt <= 1) begin
				m_tw_cnt = 0; m_state = ST_CLOSED; m_active = 0;
				return;
			end
			m_tw_cnt--;
		end
		if (m_outst) begin
			if (m_rto_cnt <= 1) begin
				if (m_retry >= m_retries) begin
					drop_conn(STS_TIMEOUT);
					return;
				end
				queue_tx(m_pseq, m_rnxt, m_pflags, m_plen);
				m_retry = m_retry + 1;
				m_rto_cnt = m_rto;
			end else begin
				m_rto_cnt--;
			end
		end
	endtask

	// Works out the results of one accepted item and notes them.
	task automatic predict_item(item_t it);
		logic [11:0] off;
		logic [12:0] taken, cap;
		logic [10:0] trim, chunk;
		logic [1:0]  kind0;
		logic [2:0]  answer_code;
		bit          answer;
		result_t     r;
		int          n;
		off = 0; taken = 0; trim = 0; kind0 = KIND_STATUS;
		answer = 0; answer_code = STS_OK;
		tx_orders.delete();
		case (action_t'(it.action))
			ACT_SEGMENT: begin
				if (m_active) begin
					m_pwin = it.seg_window;
					if (it.seg_flags[2]) begin
						drop_conn(STS_RESET);
					end else if (m_state == ST_SYN_SENT) begin
						if ((it.seg_flags & 8'h12) == 8'h12 && it.seg_ack == m_nxt) begin
							trim = apply_ack(it.seg_ack);
							m_rnxt = it.seg_sequence + 1;
							m_state = ST_ESTABLISHED;
							m_ackp = 1;
						end
					end else begin
						if (it.seg_flags[4]) trim = apply_ack(it.seg_ack);
						if (m_state != ST_CLOSED && (it.seg_length != 0 || it.seg_flags[0]))
						begin
							if (take_payload(it.seg_flags, it.seg_sequence, it.seg_length, off))
								kind0 = KIND_STORE;
						end
					end
				end
			end
			ACT_TICK: run_tick();
			ACT_CONNECT: begin
				answer = 1;
				if (m_active) begin
					answer_code = STS_BUSY;
				end else begin
					clear_conn();
					m_active = 1;
					m_una = it.initial_sequence; m_nxt = it.initial_sequence;
					m_state = ST_SYN_SENT;
					send_segment(FL_SYN, 0);
				end
			end
			ACT_SEND: begin
				answer = 1;
				chunk = it.seg_length;
				if (m_state != ST_ESTABLISHED) answer_code = STS_INVALID;
				else if (chunk == 0) answer_code = STS_OK;
				else if (m_pwin == 0) answer_code = STS_TIMEOUT;
				else begin
					if (chunk > MAX_SEGMENT) chunk = 11'(MAX_SEGMENT);
					if (32'(chunk) > 32'(m_pwin)) chunk = m_pwin[10:0];
					if (m_outst) answer_code = STS_INVALID;
					else send_segment(it.seg_flags, chunk);
				end
			end
			ACT_CLOSE: begin
				answer = 1;
				if (m_state == ST_ESTABLISHED || m_state == ST_CLOSE_WAIT) begin
					if (m_outst) begin
						answer_code = STS_BUSY;
					end else begin
						m_state = (m_state == ST_ESTABLISHED) ? ST_FIN_WAIT1 : ST_LAST_ACK;
						send_segment(FL_FINACK, 0);
					end
				end else if (m_state == ST_CLOSED) begin
					m_active = 0;
					answer_code = m_status;
				end else if (m_state == ST_SYN_SENT) begin
					answer_code = STS_INVALID;
				end
			end
			ACT_READ: begin
				cap = it.read_capacity;
				taken = (m_rxc < cap) ? m_rxc : cap;
				m_rxc = m_rxc - taken;
			end
			ACT_ABORT: clear_conn();
			default: begin
				answer = 1; answer_code = STS_INVALID;
			end
		endcase
		n = (tx_orders.size() > 0) ? tx_orders.size() : 1;
		for (int k = 0; k < n; k++) begin
			if (tx_orders.size() > 0) begin
				r.kind = tx_orders[k].kind; r.out_sequence = tx_orders[k].seq;
				r.tx_ack = tx_orders[k].ack; r.out_flags = tx_orders[k].flags;
				r.out_length = tx_orders[k].len;
			end else begin
				r.kind = kind0; r.out_sequence = 0; r.tx_ack = 0;
				r.out_flags = 0; r.out_length = 0;
			end
			r.rx_write_offset = off;
			r.rx_available = m_rxc;
			r.read_taken = taken;
			r.tx_trim = trim;
			r.conn_state = m_state;
			r.status = answer ? answer_code : m_status;
			r.last = (k == n - 1);
			board.note_item(r);
		end
	endtask

	// Offers one item, waits for acceptance and predicts it.
	task automatic offer_item(item_t it);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= it.action;
		item_ch.seg_flags <= it.seg_flags;
		item_ch.seg_sequence <= it.seg_sequence;
		item_ch.seg_ack <= it.seg_ack;
		item_ch.seg_window <= it.seg_window;
		item_ch.seg_length <= it.seg_length;
		item_ch.initial_sequence <= it.initial_sequence;
		item_ch.read_capacity <= it.read_capacity;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		predict_item(it);
		item_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random noise item with every field random.
	function automatic item_t noise_item();
		item_t it;
		it.action = $urandom_range(0, 7);
		it.seg_flags = $urandom;
		it.seg_sequence = $urandom;
		it.seg_ack = $urandom;
		it.seg_window = $urandom;
		it.seg_length = $urandom;
		it.initial_sequence = $urandom;
		it.read_capacity = $urandom_range(0, 8191);
		return it;
	endfunction

	function automatic item_t make_item(action_t a, logic [7:0] f = 0, logic [31:0] s = 0,
			logic [31:0] k = 0, logic [15:0] w = 0, logic [10:0] l = 0,
			logic [31:0] iss = 0, logic [12:0] cap = 0);
		item_t it;
		it.action = a; it.seg_flags = f; it.seg_sequence = s; it.seg_ack = k;
		it.seg_window = w; it.seg_length = l; it.initial_sequence = iss;
		it.read_capacity = cap;
		return it;
	endfunction

	// Writes one register; only called while the block is idle.
	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_RETRANSMIT: m_rto = value;
			CFG_TIME_WAIT: m_twt = value;
			CFG_MAX_RETRY: m_retries = value[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// A random peer item that fits the current connection, mostly in order.
	function automatic item_t peer_item();
		item_t it;
		logic [7:0] f;
		int pick;
		it = noise_item();
		pick = $urandom_range(0, 99);
		f = FL_ACK | ($urandom_range(0, 1) ? 8'h08 : 8'h00);
		if (m_state == ST_SYN_SENT) begin
			it = make_item(ACT_SEGMENT, FL_SYN | FL_ACK, $urandom, m_nxt,
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(64, 2048));
		end else if (pick < 30) begin
			it = make_item(ACT_SEGMENT, f | ($urandom_range(0, 15) == 0 ? F_FIN : 8'h00),
				$urandom_range(0, 5) == 0 ? $urandom : m_rnxt,
				$urandom_range(0, 1) ? m_nxt : m_pseq + $urandom_range(0, 8),
				$urandom_range(0, 9) == 0 ? 16'd0 : $urandom_range(1, 3000),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 64));
		end else if (pick < 45) begin
			it = make_item(ACT_TICK);
		end else if (pick < 62) begin
			it = make_item(ACT_SEND, $urandom, 0, 0, 0,
				$urandom_range(0, 4) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 40));
		end else if (pick < 72) begin
			it = make_item(ACT_READ, 0, 0, 0, 0, 0, 0,
				$urandom_range(0, 3) == 0 ? 13'd4096 : $urandom_range(0, 300));
		end else if (pick < 80) begin
			it = make_item(ACT_CLOSE);
		end else if (pick < 86) begin
			it = make_item(ACT_CONNECT, 0, 0, 0, 0, 0, $urandom);
		end else if (pick < 88) begin
			it = make_item(ACT_ABORT);
		end else if (pick < 90) begin
			it = make_item(ACT_SEGMENT, F_RST, $urandom, $urandom, $urandom);
		end
		return it;
	endfunction

	// Long output stall while items keep being offered.
	task automatic stall_burst();
		fork
			begin
				long_stall = 1'b1;
				repeat (200) @(posedge clk);
				long_stall = 1'b0;
			end
			begin
				repeat (20) offer_item(make_item(ACT_TICK));
			end
		join
	endtask

	initial begin
		item_t it;
		logic [31:0] iss;
		m_rto = RETRANSMIT_RESET; m_twt = TIME_WAIT_RESET; m_retries = MAX_RETRY_RESET;
		clear_conn();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: handshake, data, closes, timers and errors.
		write_reg(CFG_RETRANSMIT, 16'd2);
		write_reg(CFG_TIME_WAIT, 16'd0);
		write_reg(CFG_MAX_RETRY, 16'd1);
		iss = 32'hFFFF_FFFE;
		offer_item(make_item(ACT_SEGMENT, FL_ACK, 1, 2, 3, 4));
		offer_item(make_item(ACT_SEND, 0, 0, 0, 0, 5));
		offer_item(make_item(ACT_CLOSE));
		offer_item(make_item(ACT_CONNECT, 0, 0, 0, 0, 0, iss));
		offer_item(make_item(ACT_CONNECT, 0, 0, 0, 0, 0, 32'h0));
		offer_item(make_item(ACT_CLOSE));
		offer_item(make_item(ACT_SEGMENT, FL_SYN | FL_ACK, 32'hFFFF_FFFF, iss + 1, 16'hFFFF));
		offer_item(make_item(ACT_TICK));
		offer_item(make_item(ACT_SEND, 8'hFF, 0, 0, 0, 11'h7FF));
		offer_item(make_item(ACT_SEND, 8'h18, 0, 0, 0, 11'd1));
		offer_item(make_item(ACT_SEGMENT, FL_ACK, 32'h0, iss + 1 + 700, 16'd100, 11'd0));
		offer_item(make_item(ACT_SEGMENT, FL_ACK, 32'h0, iss + 1 + 1463, 16'd100, 11'd2047));
		offer_item(make_item(ACT_SEGMENT, FL_ACK, 32'h0, iss + 1 + 1463, 16'd100, 11'd2047));
		offer_item(make_item(ACT_SEGMENT, FL_ACK, 32'h5, iss + 1 + 1463, 16'd0, 11'd10));
		offer_item(make_item(ACT_SEND, 0, 0, 0, 0, 11'd5));
		offer_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 13'd4096));
		offer_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 13'h1FFF));
		offer_item(make_item(ACT_SEGMENT, FL_ACK | F_FIN, 32'h7FF, iss + 1 + 1463));
		offer_item(make_item(ACT_CLOSE));
		offer_item(make_item(ACT_TICK));
		offer_item(make_item(ACT_TICK));
		offer_item(make_item(ACT_TICK));
		offer_item(make_item(ACT_UNKNOWN));
		offer_item(make_item(ACT_ABORT));
		wait_drained();

		// Random phases over several register settings.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_RETRANSMIT, 16'd1);
					write_reg(CFG_TIME_WAIT, 16'd1);
					write_reg(CFG_MAX_RETRY, 16'd0);
				end
				1: begin
					write_reg(CFG_RETRANSMIT, 16'hFFFF);
					write_reg(CFG_TIME_WAIT, 16'hFFFF);
					write_reg(CFG_MAX_RETRY, 16'd15);
				end
				default: begin
					write_reg(CFG_RETRANSMIT, $urandom_range(1, 6));
					write_reg(CFG_TIME_WAIT, $urandom_range(1, 6));
					write_reg(CFG_MAX_RETRY, $urandom);
				end
			endcase
			for (int n = 0; n < 270; n++) begin
				if (phase == 5 && n > 200) quiet_phase = 1'b1;
				if (phase == 2 && n == 50) stall_burst();
				if (!m_active && $urandom_range(0, 2) != 0)
					it = make_item(ACT_CONNECT, 0, 0, 0, 0, 0,
						$urandom_range(0, 7) == 0 ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom);
				else if ($urandom_range(0, 9) == 0)
					it = noise_item();
				else
					it = peer_item();
				offer_item(it);
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
